// File: sv/rexp_pkg.sv
// ----------------------------------------------------------------------------
// rexp_pkg: shared types and codes for the relay expander sequencer
// command word and result word layouts, function codes, expander registers
// ----------------------------------------------------------------------------
package rexp_pkg;

	localparam int RELAY_COUNT_DEF = 8;

	// function codes of a command word
	localparam logic [1:0] FUNC_CMD  = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_DONE = 2'd2;

	// expander register addresses
	localparam logic [1:0] REG_NONE     = 2'd0;
	localparam logic [1:0] REG_OUTPUT   = 2'd1;
	localparam logic [1:0] REG_POLARITY = 2'd2;
	localparam logic [1:0] REG_CONFIG   = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_BUS    = 2'd1;
	localparam logic [1:0] ERR_VERIFY = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [2:0] relay_index;
		logic       relay_on;
		logic       xfer_ok;
		logic [7:0] read_data;
	} cmd_t;

	typedef struct packed {
		logic        req_valid;
		logic        req_read;
		logic [1:0]  req_reg;
		logic [7:0]  req_data;
		logic        busy_res;
		logic [7:0]  confirmed_mask;
		logic [7:0]  commanded_mask;
		logic        healthy;
		logic [1:0]  fault_code;
		logic [15:0] bus_error_count;
		logic [15:0] verify_fail_count;
		logic [15:0] recovery_count;
	} res_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

// File: sv/rexp_if.sv
// ----------------------------------------------------------------------------
// rexp_cmd_if / rexp_res_if: valid-ready channels of the sequencer
// one word moves at a clock edge with valid and ready both high
// ----------------------------------------------------------------------------
interface rexp_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [2:0] relay_index;
	logic       relay_on;
	logic       xfer_ok;
	logic [7:0] read_data;

	modport source (output valid, func, relay_index, relay_on, xfer_ok, read_data,
		input ready);
	modport sink (input valid, func, relay_index, relay_on, xfer_ok, read_data,
		output ready);
endinterface

interface rexp_res_if;
	logic        valid;
	logic        ready;
	logic        req_valid;
	logic        req_read;
	logic [1:0]  req_reg;
	logic [7:0]  req_data;
	logic        busy_res;
	logic [7:0]  confirmed_mask;
	logic [7:0]  commanded_mask;
	logic        healthy;
	logic [1:0]  fault_code;
	logic [15:0] bus_error_count;
	logic [15:0] verify_fail_count;
	logic [15:0] recovery_count;

	modport source (output valid, req_valid, req_read, req_reg, req_data, busy_res,
		confirmed_mask, commanded_mask, healthy, fault_code, bus_error_count,
		verify_fail_count, recovery_count, input ready);
	modport sink (input valid, req_valid, req_read, req_reg, req_data, busy_res,
		confirmed_mask, commanded_mask, healthy, fault_code, bus_error_count,
		verify_fail_count, recovery_count, output ready);
endinterface

// File: sv/rexp_seq.sv
// ----------------------------------------------------------------------------
// rexp_seq: write-and-verify sequencer state and next-state logic
// updates the state on each accepted word and forms the matching result
// ----------------------------------------------------------------------------
module rexp_seq #(
	parameter int RELAY_COUNT = rexp_pkg::RELAY_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  rexp_pkg::cmd_t  cmd,
	output rexp_pkg::res_t  res
);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_WR_OUT = 3'd1,
		PH_RD_CFG = 3'd2,
		PH_RD_OUT = 3'd3,
		PH_WR_POL = 3'd4,
		PH_WR_CFG = 3'd5
	} phase_t;

	localparam logic [3:0] RelayLimit = 4'(RELAY_COUNT);

	phase_t      phase_q, phase_d;
	logic [7:0]  wanted_q, wanted_d;
	logic [7:0]  verified_q, verified_d;
	logic [7:0]  target_q, target_d;
	logic [7:0]  rb_cfg_q, rb_cfg_d;
	logic        recov_q, recov_d;
	logic        restart_q, restart_d;
	logic        exp_ok_q, exp_ok_d;
	logic [1:0]  err_q, err_d;
	logic [15:0] bus_cnt_q, bus_cnt_d;
	logic [15:0] vfy_cnt_q, vfy_cnt_d;
	logic [15:0] rec_cnt_q, rec_cnt_d;

	logic        do_start;
	logic        rq_valid, rq_read;
	logic [1:0]  rq_reg;
	logic [7:0]  rq_data;
	logic [7:0]  bit_sel;

	assign bit_sel = 8'(1) << cmd.relay_index;

	always_comb begin
		phase_d   = phase_q;
		wanted_d  = wanted_q;
		verified_d = verified_q;
		target_d  = target_q;
		rb_cfg_d  = rb_cfg_q;
		recov_d   = recov_q;
		restart_d = restart_q;
		exp_ok_d  = exp_ok_q;
		err_d     = err_q;
		bus_cnt_d = bus_cnt_q;
		vfy_cnt_d = vfy_cnt_q;
		rec_cnt_d = rec_cnt_q;
		do_start  = 1'b0;
		rq_valid  = 1'b0;
		rq_read   = 1'b0;
		rq_reg    = rexp_pkg::REG_NONE;
		rq_data   = 8'd0;

		case (cmd.func)
			rexp_pkg::FUNC_CMD: begin
				if ({1'b0, cmd.relay_index} < RelayLimit) begin
					wanted_d = cmd.relay_on ? (wanted_q | bit_sel) : (wanted_q & ~bit_sel);
					if (phase_q == PH_IDLE)
						do_start = 1'b1;
					else
						restart_d = 1'b1;
				end
			end
			rexp_pkg::FUNC_TICK: begin
				if (phase_q == PH_IDLE)
					do_start = 1'b1;
			end
			rexp_pkg::FUNC_DONE: begin
				if (phase_q != PH_IDLE) begin
					if (!cmd.xfer_ok) begin
						exp_ok_d  = 1'b0;
						bus_cnt_d = rexp_pkg::sat_inc(bus_cnt_q);
						err_d     = rexp_pkg::ERR_BUS;
					end
					if (restart_q) begin
						do_start = 1'b1;
					end else if (!cmd.xfer_ok) begin
						recov_d = 1'b0;
						phase_d = PH_IDLE;
					end else begin
						unique case (phase_q) inside
							PH_WR_OUT, PH_WR_CFG: begin
								rq_valid = 1'b1;
								rq_read  = 1'b1;
								rq_reg   = rexp_pkg::REG_CONFIG;
								phase_d  = PH_RD_CFG;
							end
							PH_RD_CFG: begin
								rb_cfg_d = cmd.read_data;
								rq_valid = 1'b1;
								rq_read  = 1'b1;
								rq_reg   = rexp_pkg::REG_OUTPUT;
								phase_d  = PH_RD_OUT;
							end
							PH_RD_OUT: begin
								// readback check
								if (cmd.read_data != target_q || (rb_cfg_q != 8'd0 && recov_q))
								begin
									exp_ok_d  = 1'b0;
									vfy_cnt_d = rexp_pkg::sat_inc(vfy_cnt_q);
									err_d     = rexp_pkg::ERR_VERIFY;
									recov_d   = 1'b0;
									phase_d   = PH_IDLE;
								end else if (rb_cfg_q != 8'd0) begin
									recov_d  = 1'b1;
									exp_ok_d = 1'b0;
									rq_valid = 1'b1;
									rq_reg   = rexp_pkg::REG_POLARITY;
									phase_d  = PH_WR_POL;
								end else begin
									verified_d = target_q;
									exp_ok_d   = 1'b1;
									err_d      = rexp_pkg::ERR_NONE;
									if (recov_q)
										rec_cnt_d = rexp_pkg::sat_inc(rec_cnt_q);
									recov_d = 1'b0;
									phase_d = PH_IDLE;
								end
							end
							PH_WR_POL: begin
								rq_valid = 1'b1;
								rq_reg   = rexp_pkg::REG_CONFIG;
								phase_d  = PH_WR_CFG;
							end
							default: begin
								recov_d = 1'b0;
								phase_d = PH_IDLE;
							end
						endcase
					end
				end
			end
			default: ;
		endcase

		if (do_start) begin
			target_d  = wanted_d;
			recov_d   = 1'b0;
			restart_d = 1'b0;
			rq_valid  = 1'b1;
			rq_read   = 1'b0;
			rq_reg    = rexp_pkg::REG_OUTPUT;
			rq_data   = wanted_d;
			phase_d   = PH_WR_OUT;
		end
	end

	always_comb begin
		res.req_valid         = rq_valid;
		res.req_read          = rq_read;
		res.req_reg           = rq_reg;
		res.req_data          = rq_data;
		res.busy_res          = (phase_d != PH_IDLE);
		res.confirmed_mask    = verified_d;
		res.commanded_mask    = wanted_d;
		res.healthy           = exp_ok_d && (wanted_d == verified_d);
		res.fault_code        = err_d;
		res.bus_error_count   = bus_cnt_d;
		res.verify_fail_count = vfy_cnt_d;
		res.recovery_count    = rec_cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			wanted_q   <= 8'd0;
			verified_q <= 8'd0;
			target_q   <= 8'd0;
			rb_cfg_q   <= 8'd0;
			recov_q    <= 1'b0;
			restart_q  <= 1'b0;
			exp_ok_q   <= 1'b0;
			err_q      <= rexp_pkg::ERR_NONE;
			bus_cnt_q  <= 16'd0;
			vfy_cnt_q  <= 16'd0;
			rec_cnt_q  <= 16'd0;
		end else if (step) begin
			phase_q    <= phase_d;
			wanted_q   <= wanted_d;
			verified_q <= verified_d;
			target_q   <= target_d;
			rb_cfg_q   <= rb_cfg_d;
			recov_q    <= recov_d;
			restart_q  <= restart_d;
			exp_ok_q   <= exp_ok_d;
			err_q      <= err_d;
			bus_cnt_q  <= bus_cnt_d;
			vfy_cnt_q  <= vfy_cnt_d;
			rec_cnt_q  <= rec_cnt_d;
		end
	end

endmodule

// File: sv/rexp_res_reg.sv
// ----------------------------------------------------------------------------
// rexp_res_reg: result register between sequencer and output channel
// takes a new word whenever empty or being drained in the same cycle
// ----------------------------------------------------------------------------
module rexp_res_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rexp_pkg::res_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output rexp_pkg::res_t  out_data
);

	logic           valid_q;
	rexp_pkg::res_t data_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			data_q <= in_data;
	end

endmodule

// File: sv/relay_expander_verified_write.sv
// a result word is ready in the cycle after its command word is accepted
// throughput: one command word per cycle while the result register has room;
// a full result register accepts a new word when drained
// reset: arst_n clears all masks, counters, error and sequence state to idle
// and empties the result register
// ----------------------------------------------------------------------------
// relay_expander_verified_write: relay expander write-and-verify sequencer
// issues latch write, config and output readback, and config recovery
// ----------------------------------------------------------------------------
module relay_expander_verified_write #(
	parameter int RELAY_COUNT = rexp_pkg::RELAY_COUNT_DEF
) (
	input logic          clk,
	input logic          arst_n,
	rexp_cmd_if.sink     cmd,
	rexp_res_if.source   res
);

	rexp_pkg::cmd_t cmd_word;
	rexp_pkg::res_t next_res;
	rexp_pkg::res_t res_word;
	logic           step;
	logic           slot_ready;

	// gather the command word fields
	assign cmd_word.func        = cmd.func;
	assign cmd_word.relay_index = cmd.relay_index;
	assign cmd_word.relay_on    = cmd.relay_on;
	assign cmd_word.xfer_ok     = cmd.xfer_ok;
	assign cmd_word.read_data   = cmd.read_data;

	// every command word produces exactly one result word, so acceptance
	// follows room in the result register
	assign cmd.ready = slot_ready;
	assign step      = cmd.valid && slot_ready;

	// sequencer state machine; state advances only on accepted words
	rexp_seq #(
		.RELAY_COUNT(RELAY_COUNT)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cmd    (cmd_word),
		.res    (next_res)
	);

	// result register decouples the output handshake from acceptance
	rexp_res_reg u_res_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (slot_ready),
		.in_data   (next_res),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_data  (res_word)
	);

	// spread the result word onto the channel
	assign res.req_valid         = res_word.req_valid;
	assign res.req_read          = res_word.req_read;
	assign res.req_reg           = res_word.req_reg;
	assign res.req_data          = res_word.req_data;
	assign res.busy_res          = res_word.busy_res;
	assign res.confirmed_mask    = res_word.confirmed_mask;
	assign res.commanded_mask    = res_word.commanded_mask;
	assign res.healthy           = res_word.healthy;
	assign res.fault_code        = res_word.fault_code;
	assign res.bus_error_count   = res_word.bus_error_count;
	assign res.verify_fail_count = res_word.verify_fail_count;
	assign res.recovery_count    = res_word.recovery_count;

endmodule
